### hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Function codes, widths and the control word that travels down the chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned FUNC_W        = 4;
    localparam int unsigned FRAC_BITS_DEF = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_NEG      = 4'd4,
        FN_INC      = 4'd5,
        FN_DEC      = 4'd6,
        FN_CMP      = 4'd7,
        FN_MAX      = 4'd8,
        FN_MIN      = 4'd9,
        FN_FROM_INT = 4'd10,
        FN_TO_INT   = 4'd11
    } func_t;

    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        logic              eq;
        logic              gt;
        logic              lt;
        logic              dz;
        logic              neg;
    } ctl_t;

endpackage

### hw/rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU front stage
// Decodes the word, works out the simple results, the magnitude product and
// the dividend and divisor for the divide chain, and registers them.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int unsigned NW        = 34 + FRAC_BITS,
    parameter int unsigned DW        = 33
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [fpa_pkg::FUNC_W-1:0]          func,
    input  logic signed [fpa_pkg::DATA_W-1:0]   operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0]   operand_b,
    output fpa_pkg::ctl_t                       ctl_reg,
    output logic [fpa_pkg::DATA_W-1:0]          simple_reg,
    output logic [2*fpa_pkg::DATA_W-1:0]        prod_reg,
    output logic [NW-1:0]                       num_reg,
    output logic [DW-1:0]                       den_reg
);

    fpa_pkg::ctl_t                      ctl_next;
    logic [fpa_pkg::DATA_W-1:0]         simple_next;
    logic [fpa_pkg::DATA_W-1:0]         ma;
    logic [fpa_pkg::DATA_W-1:0]         mb;

    always_comb begin
        ma = operand_a[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-operand_a) : operand_a;
        mb = operand_b[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-operand_b) : operand_b;

        ctl_next.valid = in_valid;
        ctl_next.func  = func;
        ctl_next.eq    = (operand_a == operand_b);
        ctl_next.gt    = (operand_a > operand_b);
        ctl_next.lt    = (operand_a < operand_b);
        ctl_next.neg   = operand_a[fpa_pkg::DATA_W-1] ^ operand_b[fpa_pkg::DATA_W-1];
        ctl_next.dz    = (func == fpa_pkg::FN_DIV) && (mb == '0);

        case (func)
            fpa_pkg::FN_ADD:      simple_next = operand_a + operand_b;
            fpa_pkg::FN_SUB:      simple_next = operand_a - operand_b;
            fpa_pkg::FN_NEG:      simple_next = fpa_pkg::DATA_W'(-operand_a);
            fpa_pkg::FN_INC:      simple_next = operand_a + 1'b1;
            fpa_pkg::FN_DEC:      simple_next = operand_a - 1'b1;
            fpa_pkg::FN_MAX:      simple_next = ctl_next.gt ? operand_a : operand_b;
            fpa_pkg::FN_MIN:      simple_next = ctl_next.lt ? operand_a : operand_b;
            fpa_pkg::FN_FROM_INT: simple_next = operand_a << FRAC_BITS;
            fpa_pkg::FN_TO_INT:   simple_next = operand_a >>> FRAC_BITS;
            default:              simple_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    // Dividend carries the rounding half: 2*(ma << F) + mb over 2*mb
    always_ff @(posedge aclk) begin
        if (en) begin
            simple_reg <= simple_next;
            prod_reg   <= (2*fpa_pkg::DATA_W)'(ma) * (2*fpa_pkg::DATA_W)'(mb);
            num_reg    <= (NW'(ma) << (FRAC_BITS + 1)) + NW'(mb);
            den_reg    <= {mb, 1'b0};
        end
    end

endmodule

### hw/rtl/fpa_cell.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU divide cell
// One restoring-division step: shift in a dividend bit, trial subtract,
// emit one quotient bit, and hand the word on to the next cell.
// ----------------------------------------------------------------------------
module fpa_cell #(
    parameter int unsigned NW = 42,
    parameter int unsigned DW = 33
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  fpa_pkg::ctl_t                    ctl_in,
    input  logic [fpa_pkg::DATA_W-1:0]       simple_in,
    input  logic [2*fpa_pkg::DATA_W-1:0]     prod_in,
    input  logic [NW-1:0]                    num_in,
    input  logic [DW-1:0]                    den_in,
    input  logic [DW-1:0]                    rem_in,
    input  logic [NW-1:0]                    quo_in,
    output fpa_pkg::ctl_t                    ctl_reg,
    output logic [fpa_pkg::DATA_W-1:0]       simple_reg,
    output logic [2*fpa_pkg::DATA_W-1:0]     prod_reg,
    output logic [NW-1:0]                    num_reg,
    output logic [DW-1:0]                    den_reg,
    output logic [DW-1:0]                    rem_reg,
    output logic [NW-1:0]                    quo_reg
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          qbit;
    logic [DW-1:0] rem_next;

    always_comb begin
        trial    = {rem_in, num_in[NW-1]};
        diff     = trial - {1'b0, den_in};
        qbit     = (trial >= {1'b0, den_in});
        rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            simple_reg <= simple_in;
            prod_reg   <= prod_in;
            num_reg    <= num_in << 1;
            den_reg    <= den_in;
            rem_reg    <= rem_next;
            quo_reg    <= {quo_in[NW-2:0], qbit};
        end
    end

endmodule

### hw/rtl/fpa_tail.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU tail stage
// Rounds the product, saturates multiply and divide results, picks the
// final value and holds it in the output register.
// ----------------------------------------------------------------------------
module fpa_tail #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int unsigned NW        = 34 + FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  fpa_pkg::ctl_t                    ctl_in,
    input  logic [fpa_pkg::DATA_W-1:0]       simple_in,
    input  logic [2*fpa_pkg::DATA_W-1:0]     prod_in,
    input  logic [NW-1:0]                    quo_in,
    output logic                             valid_reg,
    output logic [fpa_pkg::DATA_W-1:0]       result_reg,
    output logic                             eq_reg,
    output logic                             gt_reg,
    output logic                             lt_reg,
    output logic                             dz_reg,
    output logic                             ovf_reg
);

    localparam int unsigned MW = 2 * fpa_pkg::DATA_W;

    logic [MW-1:0]              mul_mag;
    logic [MW-1:0]              mag;
    logic                       sneg;
    logic                       sat;
    logic                       arith;
    logic [fpa_pkg::DATA_W-1:0] sat_val;
    logic [fpa_pkg::DATA_W-1:0] result_next;
    logic                       ovf_next;

    always_comb begin
        mul_mag = (prod_in + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        mag     = (ctl_in.func == fpa_pkg::FN_MUL) ? mul_mag : MW'(quo_in);
        sneg    = ctl_in.neg && (mag != '0);
        sat     = sneg ? (mag > MW'(33'h0_8000_0000)) : (mag > MW'(32'h7FFF_FFFF));
        if (sat) begin
            sat_val = sneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat_val = sneg ? fpa_pkg::DATA_W'(-mag[fpa_pkg::DATA_W-1:0])
                           : mag[fpa_pkg::DATA_W-1:0];
        end

        arith = (ctl_in.func == fpa_pkg::FN_MUL) ||
                ((ctl_in.func == fpa_pkg::FN_DIV) && !ctl_in.dz);
        if (arith) begin
            result_next = sat_val;
            ovf_next    = sat;
        end else begin
            // divide by zero gives zero; everything else was settled up front
            result_next = (ctl_in.func == fpa_pkg::FN_DIV) ? '0 : simple_in;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
            eq_reg     <= ctl_in.eq;
            gt_reg     <= ctl_in.gt;
            lt_reg     <= ctl_in.lt;
            dz_reg     <= ctl_in.dz;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

### hw/rtl/fixed_point_q8_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Add, subtract, multiply, divide, negate, step, compare, min/max and
// integer conversions on 32-bit raw fixed-point words.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the row advances, and each word yields
// one result word. The path is a front stage with the product multiplier, a
// row of FRAC_BITS + 34 divide cells each producing one quotient bit, and a
// tail stage that rounds, saturates and holds the result. All operations
// travel the same path so results leave in order. The whole row advances
// whenever the output register is empty or being taken, and s_ready is
// that same advance condition.
module fixed_point_q8_alu #(
    parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fpa_pkg::FUNC_W-1:0]        s_func,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] s_operand_b,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [fpa_pkg::DATA_W-1:0] m_result,
    output logic                              m_is_equal,
    output logic                              m_is_greater,
    output logic                              m_is_less,
    output logic                              m_div_by_zero,
    output logic                              m_overflow
);

    localparam int unsigned NW = 34 + FRAC_BITS;
    localparam int unsigned DW = fpa_pkg::DATA_W + 1;

    logic en;

    fpa_pkg::ctl_t                  ctl    [0:NW];
    logic [fpa_pkg::DATA_W-1:0]     simple [0:NW];
    logic [2*fpa_pkg::DATA_W-1:0]   prod   [0:NW];
    logic [NW-1:0]                  num    [0:NW];
    logic [DW-1:0]                  den    [0:NW];
    logic [DW-1:0]                  rem    [0:NW];
    logic [NW-1:0]                  quo    [0:NW];
    logic [fpa_pkg::DATA_W-1:0]     result_w;

    // advance the whole row unless the output word is stuck
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign rem[0] = '0;
    assign quo[0] = '0;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW),
        .DW        (DW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .func       (s_func),
        .operand_a  (s_operand_a),
        .operand_b  (s_operand_b),
        .ctl_reg    (ctl[0]),
        .simple_reg (simple[0]),
        .prod_reg   (prod[0]),
        .num_reg    (num[0]),
        .den_reg    (den[0])
    );

    for (genvar i = 0; i < NW; i++) begin : g_cell
        fpa_cell #(
            .NW (NW),
            .DW (DW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .ctl_in     (ctl[i]),
            .simple_in  (simple[i]),
            .prod_in    (prod[i]),
            .num_in     (num[i]),
            .den_in     (den[i]),
            .rem_in     (rem[i]),
            .quo_in     (quo[i]),
            .ctl_reg    (ctl[i+1]),
            .simple_reg (simple[i+1]),
            .prod_reg   (prod[i+1]),
            .num_reg    (num[i+1]),
            .den_reg    (den[i+1]),
            .rem_reg    (rem[i+1]),
            .quo_reg    (quo[i+1])
        );
    end

    fpa_tail #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_tail (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctl_in     (ctl[NW]),
        .simple_in  (simple[NW]),
        .prod_in    (prod[NW]),
        .quo_in     (quo[NW]),
        .valid_reg  (m_valid),
        .result_reg (result_w),
        .eq_reg     (m_is_equal),
        .gt_reg     (m_is_greater),
        .lt_reg     (m_is_less),
        .dz_reg     (m_div_by_zero),
        .ovf_reg    (m_overflow)
    );

    assign m_result = result_w;

endmodule
